@@ design/stga_pkg.sv @@
package stga_pkg;

   // field widths
   localparam int unsigned ID_W    = 32;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned CHUNK_W = 16;
   localparam int unsigned KIND_W  = 2;

   // result slots that one item can produce, in output order
   localparam int unsigned NUM_SLOTS = 8;
   localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

   localparam logic [SLOT_W-1:0] SLOT_OLD_CHUNK  = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_OLD_SUBJ   = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_OLD_PRED   = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_ELEM       = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_EARLY_CHNK = SLOT_W'(4);
   localparam logic [SLOT_W-1:0] SLOT_LAST_CHUNK = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SLOT_LAST_SUBJ  = SLOT_W'(6);
   localparam logic [SLOT_W-1:0] SLOT_LAST_PRED  = SLOT_W'(7);

   // register reset and queue sizing
   localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RESET = CHUNK_W'(2000);
   localparam int unsigned        QUEUE_DEPTH_DEF   = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_ELEM  = 2'd0,
      KIND_CHUNK = 2'd1,
      KIND_SUBJ  = 2'd2,
      KIND_PRED  = 2'd3
   } kind_type;

   // one classified item: which slots fire and the values they carry
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [ID_W-1:0]      old_pred;
      logic [ID_W-1:0]      old_subj;
      logic [ID_W-1:0]      pred;
      logic [ID_W-1:0]      subj;
      logic [ID_W-1:0]      obj;
      logic [CHUNK_W-1:0]   old_chunk;
      logic [CNT_W-1:0]     old_group;
      logic [CNT_W-1:0]     old_dist;
      logic [CNT_W-1:0]     unique_cnt;
      logic [CHUNK_W-1:0]   early_chunk;
      logic [CHUNK_W-1:0]   last_chunk;
      logic [CNT_W-1:0]     last_group;
      logic [CNT_W-1:0]     last_dist;
   } cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

@@ design/sorted_triple_group_aggregator.sv @@
// results pass the command queue, the back end command register and the output register
// throughput: one result per cycle unless stalled; an item keeps the back end until done
// the front end takes one item per cycle until the QUEUE_DEPTH command queue fills
// items that give no result (duplicates) use no queue entry
// reset is synchronous, clears all stream state and sets chunk_limit to 2000
module sorted_triple_group_aggregator
   import stga_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ID_W-1:0]    req_pred_id,
   input  logic [ID_W-1:0]    req_subj_id,
   input  logic [ID_W-1:0]    req_obj_id,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [ID_W-1:0]    rsp_out_pred,
   output logic [ID_W-1:0]    rsp_out_subj,
   output logic [ID_W-1:0]    rsp_out_obj,
   output logic [CNT_W-1:0]   rsp_count,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CHUNK_W-1:0] csr_chunk_limit
);

   logic    q_full;
   logic    q_empty;
   logic    q_push;
   logic    q_pop;
   logic    accept;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // input transfer while the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign csr_ready = 1'b1;

   stga_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_pred_id     (req_pred_id),
      .req_subj_id     (req_subj_id),
      .req_obj_id      (req_obj_id),
      .req_last_item   (req_last_item),
      .csr_write       (csr_valid),
      .csr_chunk_limit (csr_chunk_limit),
      .push            (q_push),
      .cmd             (push_cmd)
   );

   stga_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head_cmd)
   );

   stga_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_pred    (rsp_out_pred),
      .rsp_out_subj    (rsp_out_subj),
      .rsp_out_obj     (rsp_out_obj),
      .rsp_count       (rsp_count),
      .rsp_last_result (rsp_last_result)
   );

endmodule

@@ design/stga_front.sv @@
module stga_front
   import stga_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [ID_W-1:0]    req_pred_id,
   input  logic [ID_W-1:0]    req_subj_id,
   input  logic [ID_W-1:0]    req_obj_id,
   input  logic               req_last_item,
   input  logic               csr_write,
   input  logic [CHUNK_W-1:0] csr_chunk_limit,
   output logic               push,
   output cmd_type            cmd
);

   logic               started_ff, started_in;
   logic [ID_W-1:0]    cur_pred_ff, cur_pred_in;
   logic [ID_W-1:0]    cur_subj_ff, cur_subj_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [ID_W-1:0]    prev_pred_ff, prev_pred_in;
   logic [ID_W-1:0]    prev_subj_ff, prev_subj_in;
   logic [ID_W-1:0]    prev_oid_ff, prev_oid_in;
   logic [CNT_W-1:0]   group_ff, group_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]   dist_ff, dist_in;
   logic [CNT_W-1:0]   unique_ff, unique_in;
   logic [CHUNK_W-1:0] limit_ff;

   logic               pred_chg;
   logic               subj_chg;
   logic               dup;
   logic               early;
   logic [CHUNK_W-1:0] chunk_a, chunk_b, chunk_c;
   logic [CNT_W-1:0]   group_a, group_b;
   logic [CNT_W-1:0]   dist_a;
   logic [CNT_W-1:0]   unique_b;

   // classify the item and work out the counters after each step
   always_comb begin
      pred_chg = started_ff && (req_pred_id != cur_pred_ff);
      subj_chg = started_ff && !pred_chg && (req_subj_id != cur_subj_ff);
      dup      = prev_valid_ff && (prev_pred_ff == req_pred_id) &&
                 (prev_subj_ff == req_subj_id) && (prev_oid_ff == req_obj_id);

      // group closes
      chunk_a = pred_chg ? '0 : chunk_ff;
      group_a = (pred_chg || subj_chg) ? '0 : group_ff;
      dist_a  = pred_chg ? CNT_W'(1) : (subj_chg ? sat_inc(dist_ff) : dist_ff);

      // element
      unique_b = dup ? unique_ff : sat_inc(unique_ff);
      group_b  = dup ? group_a : sat_inc(group_a);
      chunk_b  = (dup || chunk_a == '1) ? chunk_a : chunk_a + CHUNK_W'(1);
      early    = !dup && (chunk_b >= limit_ff);
      chunk_c  = early ? '0 : chunk_b;

      // command for the back end
      cmd.mask                  = '0;
      cmd.mask[SLOT_OLD_CHUNK]  = pred_chg;
      cmd.mask[SLOT_OLD_SUBJ]   = pred_chg || subj_chg;
      cmd.mask[SLOT_OLD_PRED]   = pred_chg;
      cmd.mask[SLOT_ELEM]       = !dup;
      cmd.mask[SLOT_EARLY_CHNK] = early;
      cmd.mask[SLOT_LAST_CHUNK] = req_last_item;
      cmd.mask[SLOT_LAST_SUBJ]  = req_last_item;
      cmd.mask[SLOT_LAST_PRED]  = req_last_item;
      cmd.old_pred    = cur_pred_ff;
      cmd.old_subj    = cur_subj_ff;
      cmd.pred        = req_pred_id;
      cmd.subj        = req_subj_id;
      cmd.obj         = req_obj_id;
      cmd.old_chunk   = chunk_ff;
      cmd.old_group   = group_ff;
      cmd.old_dist    = dist_ff;
      cmd.unique_cnt  = unique_b;
      cmd.early_chunk = chunk_b;
      cmd.last_chunk  = chunk_c;
      cmd.last_group  = group_b;
      cmd.last_dist   = dist_a;

      push = accept && (cmd.mask != '0);

      // next state
      started_in    = started_ff;
      cur_pred_in   = cur_pred_ff;
      cur_subj_in   = cur_subj_ff;
      prev_valid_in = prev_valid_ff;
      prev_pred_in  = prev_pred_ff;
      prev_subj_in  = prev_subj_ff;
      prev_oid_in   = prev_oid_ff;
      group_in      = group_ff;
      chunk_in      = chunk_ff;
      dist_in       = dist_ff;
      unique_in     = unique_ff;
      if (accept) begin
         if (req_last_item) begin
            started_in    = 1'b0;
            cur_pred_in   = '0;
            cur_subj_in   = '0;
            prev_valid_in = 1'b0;
            prev_pred_in  = '0;
            prev_subj_in  = '0;
            prev_oid_in   = '0;
            group_in      = '0;
            chunk_in      = '0;
            dist_in       = CNT_W'(1);
            unique_in     = '0;
         end else begin
            started_in  = 1'b1;
            cur_pred_in = req_pred_id;
            cur_subj_in = req_subj_id;
            if (!dup) begin
               prev_valid_in = 1'b1;
               prev_pred_in  = req_pred_id;
               prev_subj_in  = req_subj_id;
               prev_oid_in   = req_obj_id;
            end
            group_in  = group_b;
            chunk_in  = chunk_c;
            dist_in   = dist_a;
            unique_in = unique_b;
         end
      end
   end

   // stream state and chunk limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         cur_pred_ff   <= '0;
         cur_subj_ff   <= '0;
         prev_valid_ff <= 1'b0;
         prev_pred_ff  <= '0;
         prev_subj_ff  <= '0;
         prev_oid_ff   <= '0;
         group_ff      <= '0;
         chunk_ff      <= '0;
         dist_ff       <= CNT_W'(1);
         unique_ff     <= '0;
         limit_ff      <= CHUNK_LIMIT_RESET;
      end else begin
         started_ff    <= started_in;
         cur_pred_ff   <= cur_pred_in;
         cur_subj_ff   <= cur_subj_in;
         prev_valid_ff <= prev_valid_in;
         prev_pred_ff  <= prev_pred_in;
         prev_subj_ff  <= prev_subj_in;
         prev_oid_ff   <= prev_oid_in;
         group_ff      <= group_in;
         chunk_ff      <= chunk_in;
         dist_ff       <= dist_in;
         unique_ff     <= unique_in;
         if (csr_write) begin
            limit_ff <= csr_chunk_limit;
         end
      end
   end

endmodule

@@ design/stga_queue.sv @@
module stga_queue
   import stga_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]   fill_ff, fill_in;

   assign full  = (fill_ff == CNT_W_Q'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W_Q'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/stga_back.sv @@
module stga_back
   import stga_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  cmd_type            q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [ID_W-1:0]    rsp_out_pred,
   output logic [ID_W-1:0]    rsp_out_subj,
   output logic [ID_W-1:0]    rsp_out_obj,
   output logic [CNT_W-1:0]   rsp_count,
   output logic               rsp_last_result
);

   cmd_type              cur_ff, cur_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [ID_W-1:0]      pred_ff, pred_in;
   logic [ID_W-1:0]      subj_ff, subj_in;
   logic [ID_W-1:0]      obj_ff, obj_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 emit;
   logic [SLOT_W-1:0]    sel;
   logic [NUM_SLOTS-1:0] rest;
   logic [NUM_SLOTS-1:0] remain;

   // lowest pending slot goes out next
   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SLOT_W'(i);
         end
      end
      rest = mask_ff & ~(NUM_SLOTS'(1) << sel);
   end

   // slot to record
   always_comb begin
      kind_in  = KIND_CHUNK;
      pred_in  = cur_ff.pred;
      subj_in  = '0;
      obj_in   = '0;
      count_in = '0;
      case (sel)
         SLOT_OLD_CHUNK: begin
            pred_in  = cur_ff.old_pred;
            count_in = CNT_W'(cur_ff.old_chunk);
         end
         SLOT_OLD_SUBJ: begin
            kind_in  = KIND_SUBJ;
            pred_in  = cur_ff.old_pred;
            subj_in  = cur_ff.old_subj;
            count_in = cur_ff.old_group;
         end
         SLOT_OLD_PRED: begin
            kind_in  = KIND_PRED;
            pred_in  = cur_ff.old_pred;
            count_in = cur_ff.old_dist;
         end
         SLOT_ELEM: begin
            kind_in  = KIND_ELEM;
            subj_in  = cur_ff.subj;
            obj_in   = cur_ff.obj;
            count_in = cur_ff.unique_cnt;
         end
         SLOT_EARLY_CHNK: begin
            count_in = CNT_W'(cur_ff.early_chunk);
         end
         SLOT_LAST_CHUNK: begin
            count_in = CNT_W'(cur_ff.last_chunk);
         end
         SLOT_LAST_SUBJ: begin
            kind_in  = KIND_SUBJ;
            subj_in  = cur_ff.subj;
            count_in = cur_ff.last_group;
         end
         SLOT_LAST_PRED: begin
            kind_in  = KIND_PRED;
            count_in = cur_ff.last_dist;
         end
         default: begin
            kind_in = KIND_CHUNK;
         end
      endcase
      last_in = (rest == '0);
   end

   // sequencing and output register handshake
   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      emit     = out_free && (mask_ff != '0);
      remain   = emit ? rest : mask_ff;
      q_pop    = !q_empty && (remain == '0);
      mask_in  = q_pop ? q_head.mask : remain;
      cur_in   = q_pop ? q_head : cur_ff;
      valid_in = emit ? 1'b1 : (out_free ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         kind_ff  <= kind_in;
         pred_ff  <= pred_in;
         subj_ff  <= subj_in;
         obj_ff   <= obj_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_pred    = pred_ff;
   assign rsp_out_subj    = subj_ff;
   assign rsp_out_obj     = obj_ff;
   assign rsp_count       = count_ff;
   assign rsp_last_result = last_ff;

`ifndef NO_ASSERTIONS
   // a command taken from the queue always has work in it
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (mask_ff != '0))
      else $error("popped command carries no result slots");

   // only element records carry an object
   a_obj_only_elem: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_ELEM) |-> (obj_ff == '0))
      else $error("non-element record carries an object");

   // an element always has a non-zero running total
   a_elem_count: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ELEM) |-> (count_ff != '0))
      else $error("element record with zero running total");

   // the queue is never popped while a record of the current command waits
   a_pop_after_done: assert property (@(posedge clock) disable iff (reset)
      (q_pop && emit) |-> (rest == '0))
      else $error("command replaced before all its records went out");
`endif

endmodule

@@ test/sorted_triple_group_aggregator_tb.sv @@
module sorted_triple_group_aggregator_tb
   import stga_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one input triple as offered on the request side
   typedef struct {
      logic [ID_W-1:0] pred;
      logic [ID_W-1:0] subj;
      logic [ID_W-1:0] obj;
      logic            is_last;
   } triple_type;

   // one output record as it should leave the block
   typedef struct {
      kind_type         kind;
      logic [ID_W-1:0]  pred;
      logic [ID_W-1:0]  subj;
      logic [ID_W-1:0]  obj;
      logic [CNT_W-1:0] count;
      logic             is_last;
   } agg_record_type;

   localparam int unsigned GRACE_CYCLES = 10;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned IDLE_PCT     = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [ID_W-1:0]    req_pred_id = '0;
   logic [ID_W-1:0]    req_subj_id = '0;
   logic [ID_W-1:0]    req_obj_id = '0;
   logic               req_last_item = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [KIND_W-1:0]  rsp_kind;
   logic [ID_W-1:0]    rsp_out_pred;
   logic [ID_W-1:0]    rsp_out_subj;
   logic [ID_W-1:0]    rsp_out_obj;
   logic [CNT_W-1:0]   rsp_count;
   logic               rsp_last_result;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CHUNK_W-1:0] csr_chunk_limit = '0;

   sorted_triple_group_aggregator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pred_id     (req_pred_id),
      .req_subj_id     (req_subj_id),
      .req_obj_id      (req_obj_id),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_pred    (rsp_out_pred),
      .rsp_out_subj    (rsp_out_subj),
      .rsp_out_obj     (rsp_out_obj),
      .rsp_count       (rsp_count),
      .rsp_last_result (rsp_last_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_chunk_limit (csr_chunk_limit)
   );

   // bookkeeping shared by the processes
   triple_type     pending_triples[$];
   agg_record_type expected_records[$];
   agg_record_type step_records[$];
   triple_type     offered;
   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_no       = 0;
   bit          hold_armed     = 1'b0;
   bit          hold_done      = 1'b0;
   int unsigned hold_left      = 0;
   logic        calm;

   // aggregator state mirrored for prediction
   logic [CHUNK_W-1:0] limit_now      = CHUNK_LIMIT_RESET;
   bit                 stream_open    = 1'b0;
   logic [ID_W-1:0]    open_pred      = '0;
   logic [ID_W-1:0]    open_subj      = '0;
   bit                 have_prev      = 1'b0;
   logic [ID_W-1:0]    prev_pred      = '0;
   logic [ID_W-1:0]    prev_subj      = '0;
   logic [ID_W-1:0]    prev_oid       = '0;
   logic [CNT_W-1:0]   obj_in_group   = '0;
   logic [CHUNK_W-1:0] chunk_fill     = '0;
   logic [CNT_W-1:0]   subj_in_pred   = CNT_W'(1);
   logic [CNT_W-1:0]   running_unique = '0;

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // quiet window in which neither side idles at random
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end
   assign calm = (cycle_no % 3000) >= 1000 && (cycle_no % 3000) < 1700;

   function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

   task automatic emit_record(input kind_type k, input logic [ID_W-1:0] p,
                              input logic [ID_W-1:0] s, input logic [ID_W-1:0] o,
                              input logic [CNT_W-1:0] c);
      agg_record_type r;
      r.kind    = k;
      r.pred    = p;
      r.subj    = s;
      r.obj     = o;
      r.count   = c;
      r.is_last = 1'b0;
      step_records.insert(step_records.size(), r);
   endtask

   task automatic emit_chunk_close();
      emit_record(KIND_CHUNK, open_pred, '0, '0, CNT_W'(chunk_fill));
      chunk_fill = '0;
   endtask

   task automatic emit_subject_close();
      emit_record(KIND_SUBJ, open_pred, open_subj, '0, obj_in_group);
      obj_in_group = '0;
   endtask

   task automatic emit_predicate_close();
      emit_chunk_close();
      emit_subject_close();
      emit_record(KIND_PRED, open_pred, '0, '0, subj_in_pred);
      subj_in_pred = CNT_W'(1);
   endtask

   // expected records for one accepted triple, appended in output order
   task automatic predict_triple(input triple_type t);
      step_records.delete();
      if (!stream_open) begin
         stream_open = 1'b1;
         open_pred   = t.pred;
         open_subj   = t.subj;
      end else if (t.pred != open_pred) begin
         emit_predicate_close();
         open_pred = t.pred;
         open_subj = t.subj;
      end else if (t.subj != open_subj) begin
         emit_subject_close();
         subj_in_pred = bump32(subj_in_pred);
         open_subj    = t.subj;
      end

      // duplicates of the previous unique triple give no element
      if (!(have_prev && prev_pred == open_pred && prev_subj == t.subj &&
            prev_oid == t.obj)) begin
         running_unique = bump32(running_unique);
         obj_in_group   = bump32(obj_in_group);
         if (chunk_fill != '1)
            chunk_fill = chunk_fill + CHUNK_W'(1);
         emit_record(KIND_ELEM, open_pred, t.subj, t.obj, running_unique);
         have_prev = 1'b1;
         prev_pred = open_pred;
         prev_subj = t.subj;
         prev_oid  = t.obj;
         if (chunk_fill >= limit_now)
            emit_chunk_close();
      end

      // end of stream: flush and start afresh
      if (t.is_last) begin
         emit_predicate_close();
         stream_open    = 1'b0;
         open_pred      = '0;
         open_subj      = '0;
         have_prev      = 1'b0;
         prev_pred      = '0;
         prev_subj      = '0;
         prev_oid       = '0;
         obj_in_group   = '0;
         chunk_fill     = '0;
         subj_in_pred   = CNT_W'(1);
         running_unique = '0;
      end

      if (step_records.size() != 0)
         step_records[step_records.size()-1].is_last = 1'b1;
      foreach (step_records[i])
         expected_records.insert(expected_records.size(), step_records[i]);
   endtask

   // request driver: predicts on each transfer, then offers the next triple
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_triple(offered);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_triples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               offered = pending_triples.pop_front();
               req_pred_id   <= offered.pred;
               req_subj_id   <= offered.subj;
               req_obj_id    <= offered.obj;
               req_last_item <= offered.is_last;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      agg_record_type want;
      agg_record_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind    = kind_type'(rsp_kind);
            got.pred    = rsp_out_pred;
            got.subj    = rsp_out_subj;
            got.obj     = rsp_out_obj;
            got.count   = rsp_count;
            got.is_last = rsp_last_result;
            if (expected_records.size() == 0) begin
               error_count++;
               if (error_count <= 50) begin
                  $display("%0t: unexpected record, expected none", $time);
                  $display("   actual   kind=%0d pred=%h subj=%h obj=%h count=%0d last=%b",
                           got.kind, got.pred, got.subj, got.obj, got.count, got.is_last);
               end
            end else begin
               want = expected_records.pop_front();
               if (got.kind != want.kind || got.pred != want.pred || got.subj != want.subj ||
                   got.obj != want.obj || got.count != want.count ||
                   got.is_last != want.is_last) begin
                  error_count++;
                  if (error_count <= 50) begin
                     $display("%0t: record mismatch", $time);
                     $display("   expected kind=%0d pred=%h subj=%h obj=%h count=%0d last=%b",
                              want.kind, want.pred, want.subj, want.obj, want.count,
                              want.is_last);
                     $display("   actual   kind=%0d pred=%h subj=%h obj=%h count=%0d last=%b",
                              got.kind, got.pred, got.subj, got.obj, got.count, got.is_last);
                  end
               end
            end
         end

         // one long hold-off so the block fills and stalls its input
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   task automatic add_triple(input logic [ID_W-1:0] p, input logic [ID_W-1:0] s,
                             input logic [ID_W-1:0] o, input bit is_last);
      triple_type t;
      t.pred    = p;
      t.subj    = s;
      t.obj     = o;
      t.is_last = is_last;
      pending_triples.insert(pending_triples.size(), t);
      queued_count++;
   endtask

   // well-formed stream sorted by predicate, subject, object, with some duplicates
   task automatic add_stream(input bit closing);
      logic [ID_W-1:0] p;
      logic [ID_W-1:0] s;
      logic [ID_W-1:0] o;
      int unsigned     np;
      int unsigned     ns;
      int unsigned     no;
      bit              final_one;
      p  = $urandom_range(1) ? $urandom : $urandom_range(15);
      np = $urandom_range(1, 4);
      for (int i = 0; i < np; i++) begin
         ns = $urandom_range(1, 4);
         s  = $urandom_range(1) ? $urandom : $urandom_range(15);
         for (int j = 0; j < ns; j++) begin
            no = $urandom_range(1, 5);
            o  = $urandom_range(1) ? $urandom : $urandom_range(7);
            for (int k = 0; k < no; k++) begin
               final_one = closing && i == np-1 && j == ns-1 && k == no-1;
               if ($urandom_range(99) < 15) begin
                  add_triple(p, s, o, 1'b0);
                  add_triple(p, s, o, final_one);
               end else begin
                  add_triple(p, s, o, final_one);
               end
               o = o + $urandom_range(1, 1000);
            end
            s = s + $urandom_range(1, 1000);
         end
         p = p + $urandom_range(1, 1 << 20);
      end
   endtask

   // mostly sorted streams, the rest unsorted noise with stray end markers
   task automatic add_random_items(input int unsigned n);
      int unsigned target;
      int unsigned burst;
      target = queued_count + n;
      while (queued_count < target) begin
         if ($urandom_range(99) < 85) begin
            add_stream($urandom_range(99) < 80);
         end else begin
            burst = $urandom_range(1, 5);
            repeat (burst)
               add_triple($urandom_range(1) ? $urandom : $urandom_range(3),
                          $urandom_range(1) ? $urandom : $urandom_range(3),
                          $urandom_range(1) ? $urandom : $urandom_range(3),
                          $urandom_range(99) < 20);
         end
      end
   endtask

   // wait until every queued triple is taken and every record has come back
   task automatic settle_block();
      int unsigned waited;
      while (accepted_count != queued_count)
         @(posedge clock);
      waited = 0;
      while (expected_records.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (GRACE_CYCLES) @(posedge clock);
      if (expected_records.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected records never arrived, next kind=%0d pred=%h count=%0d",
                  $time, expected_records.size(), expected_records[0].kind,
                  expected_records[0].pred, expected_records[0].count);
         expected_records.delete();
      end
   endtask

   task automatic write_chunk_limit(input logic [CHUNK_W-1:0] v);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_chunk_limit <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      limit_now = v;
   endtask

   // stimulus phases
   initial begin
      @(negedge reset);

      // reset limit: leading zero triple, duplicates, extremes, flush on a duplicate
      add_triple('0, '0, '0, 1'b0);
      add_triple('0, '0, '0, 1'b0);
      add_triple('0, '0, 32'd5, 1'b0);
      add_triple('0, 32'd7, 32'd1, 1'b0);
      add_triple('0, 32'd7, 32'd1, 1'b0);
      add_triple('1, '1, '1, 1'b0);
      add_triple('1, '1, '1, 1'b1);
      add_triple(32'd5, 32'd5, 32'd5, 1'b1);
      settle_block();

      // limit of two: early close then an empty chunk on predicate change
      write_chunk_limit(CHUNK_W'(2));
      add_triple(32'd1, 32'd1, 32'd1, 1'b0);
      add_triple(32'd1, 32'd1, 32'd2, 1'b0);
      add_triple(32'd2, 32'd1, 32'd1, 1'b0);
      add_triple(32'd2, 32'd1, 32'd2, 1'b0);
      add_triple(32'd2, 32'd1, 32'd3, 1'b0);
      add_triple(32'd2, 32'd2, 32'd3, 1'b1);
      settle_block();

      // limit of one: every record an item can cause at once
      write_chunk_limit(CHUNK_W'(1));
      add_triple(32'd6, 32'd1, 32'd1, 1'b0);
      add_triple(32'd7, 32'd1, 32'd1, 1'b1);
      add_triple(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      settle_block();

      // limit of zero closes after every element too
      write_chunk_limit(CHUNK_W'(0));
      add_triple(32'd8, 32'd8, 32'd8, 1'b0);
      add_triple(32'd8, 32'd8, 32'd9, 1'b0);
      add_triple(32'd8, 32'd9, 32'd9, 1'b1);
      settle_block();

      // largest limit, with the long receiver hold-off
      write_chunk_limit('1);
      hold_armed = 1'b1;
      add_random_items(250);
      settle_block();

      // small limit so early chunk closes are frequent
      write_chunk_limit(CHUNK_W'(3));
      add_random_items(200);
      settle_block();

      write_chunk_limit(CHUNK_W'(7));
      add_random_items(60);
      settle_block();

      if (error_count == 0) begin
         $display("** sorted_triple_group_aggregator: PASSED **");
      end else begin
         $display("** sorted_triple_group_aggregator: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("** sorted_triple_group_aggregator: FAILED **");
      $finish;
   end

endmodule
